// File: src/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character map of the base64url decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned ExpWidth   = 20;  // width of expected_byte_count
  localparam int unsigned QueueDepth = 2;

  // status codes
  localparam logic [2:0] StatusOk       = 3'd0;
  localparam logic [2:0] StatusBadChar  = 3'd1;
  localparam logic [2:0] StatusBadLen   = 3'd2;
  localparam logic [2:0] StatusBadTail  = 3'd3;
  localparam logic [2:0] StatusSizeMism = 3'd4;

  // classified character, front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;   // a byte completes on this character
    logic       bad_char;
    logic       bad_len;    // last character opens a group
    logic       bad_tail;   // unused tail bits non-zero
    logic       is_last;
  } entry_t;

  // {invalid, sextet}
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] res;
    res = 7'h40;
    if (ch >= 8'h41 && ch <= 8'h5a)      res = {1'b0, 6'(ch - 8'h41)};
    else if (ch >= 8'h61 && ch <= 8'h7a) res = {1'b0, 6'(ch - 8'h61 + 8'd26)};
    else if (ch >= 8'h30 && ch <= 8'h39) res = {1'b0, 6'(ch - 8'h30 + 8'd52)};
    else if (ch == 8'h2d)                res = {1'b0, 6'd62};
    else if (ch == 8'h5f)                res = {1'b0, 6'd63};
    return res;
  endfunction

endpackage

// File: src/b64d_if.sv
// ----------------------------------------------------------------------------
// b64d interfaces
// Valid/ready channels for characters, results and the configuration write.
// ----------------------------------------------------------------------------
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;
  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface b64d_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       message_done;
  logic [2:0] status;
  modport source (output valid, output data_byte, output has_byte,
                  output message_done, output status, input ready);
  modport sink   (input valid, input data_byte, input has_byte,
                  input message_done, input status, output ready);
endinterface

interface b64d_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] expected_byte_count;
  modport source (output valid, output expected_byte_count, input ready);
  modport sink   (input valid, input expected_byte_count, output ready);
endinterface

// File: src/base64url_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// base64url_stream_decoder_top
// Streaming decoder for unpadded base64url text with end-of-message status.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                      request
//  in_i     in   char_code[7:0], is_last                      one character
//  res_o    out  data_byte[7:0], has_byte, message_done,      one result
//                status[2:0]
//  cfg_i    in   expected_byte_count[19:0]                    register write
//
//  One character per cycle sustained while res_o is ready; a result passes
//  through a queue entry, then the result register (the front is
//  combinational).
//  Stalls on res_o back up through the queue to in_i.ready; cfg_i is always
//  ready. Reset clears position, error flag, count and the expected count.
// ----------------------------------------------------------------------------
module base64url_stream_decoder_top #(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64d_char_if.sink   in_i,
  b64d_cfg_if.sink    cfg_i,
  b64d_res_if.source  res_o
);

  logic             push_valid, push_ready, pop_valid, pop_ready;
  b64d_pkg::entry_t push_data, pop_data;

  b64d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  b64d_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  b64d_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .cfg_i       (cfg_i),
    .res_o       (res_o)
  );

endmodule

// File: src/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Maps characters to sextets, tracks group position and joins bytes.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  b64d_char_if.sink         in_i,
  output logic              push_valid_o,
  output b64d_pkg::entry_t  push_data_o,
  input  logic              push_ready_i
);

  logic [1:0] pos_q, pos_d;
  logic [5:0] prev_q, prev_d;
  logic [6:0] map;
  logic [5:0] val;
  logic       accept;
  logic [7:0] joined;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid & push_ready_i;

  assign map = b64d_pkg::sextet_of(in_i.char_code);
  assign val = map[5:0];

  always_comb begin
    case (pos_q)
      2'd1:    joined = {prev_q, val[5:4]};
      2'd2:    joined = {prev_q[3:0], val[5:2]};
      2'd3:    joined = {prev_q[1:0], val};
      default: joined = 8'h00;
    endcase
  end

  always_comb begin
    push_data_o.data_byte = joined;
    push_data_o.has_byte  = (pos_q != 2'd0);
    push_data_o.bad_char  = map[6];
    push_data_o.bad_len   = (pos_q == 2'd0);
    push_data_o.bad_tail  = ((pos_q == 2'd1) && (val[3:0] != 4'h0)) ||
                            ((pos_q == 2'd2) && (val[1:0] != 2'h0));
    push_data_o.is_last   = in_i.is_last;
  end

  always_comb begin
    pos_d  = pos_q;
    prev_d = prev_q;
    if (accept) begin
      if (in_i.is_last) begin
        pos_d  = 2'd0;
        prev_d = 6'd0;
      end else begin
        pos_d  = pos_q + 2'd1;
        prev_d = val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 2'd0;
      prev_q <= 6'd0;
    end else begin
      pos_q  <= pos_d;
      prev_q <= prev_d;
    end
  end

endmodule

// File: src/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short FIFO between front and back; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module b64d_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  b64d_pkg::entry_t push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output b64d_pkg::entry_t pop_data_o,
  input  logic             pop_ready_i
);

  localparam int unsigned Depth = b64d_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  b64d_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i & push_ready_o;
  assign pop  = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    if (pop)  rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: src/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Error tracking, byte count and status; drives the registered result.
// ----------------------------------------------------------------------------
module b64d_back #(
  parameter int unsigned COUNT_WIDTH = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  input  b64d_pkg::entry_t pop_data_i,
  output logic             pop_ready_o,
  b64d_cfg_if.sink         cfg_i,
  b64d_res_if.source       res_o
);

  localparam int unsigned ExpW = b64d_pkg::ExpWidth;
  localparam int unsigned CmpW = (COUNT_WIDTH > ExpW) ? COUNT_WIDTH : ExpW;

  logic [ExpW-1:0]        expected_q;
  logic                   err_q, err_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d, count_inc;
  logic                   valid_q, valid_d;
  logic [7:0]             byte_q, byte_d;
  logic                   has_q, has_d, done_q, done_d;
  logic [2:0]             status_q, status_d;
  logic                   pop, err_now;

  assign cfg_i.ready = 1'b1;

  assign pop_ready_o = ~valid_q | res_o.ready;
  assign pop         = pop_valid_i & pop_ready_o;

  assign count_inc = (&count_q) ? count_q : count_q + COUNT_WIDTH'(1);
  assign err_now   = err_q | pop_data_i.bad_char;

  always_comb begin
    err_d    = err_q;
    count_d  = count_q;
    valid_d  = valid_q & ~res_o.ready;
    byte_d   = byte_q;
    has_d    = has_q;
    done_d   = done_q;
    status_d = status_q;
    if (pop) begin
      if (!pop_data_i.is_last) begin
        err_d = err_now;
        if (!err_now && pop_data_i.has_byte) begin
          count_d  = count_inc;
          valid_d  = 1'b1;
          byte_d   = pop_data_i.data_byte;
          has_d    = 1'b1;
          done_d   = 1'b0;
          status_d = b64d_pkg::StatusOk;
        end
      end else begin
        // precedence: length, character, tail bits, size
        if (pop_data_i.bad_len)      status_d = b64d_pkg::StatusBadLen;
        else if (err_now)            status_d = b64d_pkg::StatusBadChar;
        else if (pop_data_i.bad_tail) status_d = b64d_pkg::StatusBadTail;
        else if (CmpW'(count_inc) != CmpW'(expected_q))
                                     status_d = b64d_pkg::StatusSizeMism;
        else                         status_d = b64d_pkg::StatusOk;
        valid_d = 1'b1;
        has_d   = (status_d == b64d_pkg::StatusOk);
        byte_d  = has_d ? pop_data_i.data_byte : 8'h00;
        done_d  = 1'b1;
        err_d   = 1'b0;
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= '0;
      err_q      <= 1'b0;
      count_q    <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (cfg_i.valid) expected_q <= cfg_i.expected_byte_count;
      err_q   <= err_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    has_q    <= has_d;
    done_q   <= done_d;
    status_q <= status_d;
  end

  assign res_o.valid        = valid_q;
  assign res_o.data_byte    = byte_q;
  assign res_o.has_byte     = has_q;
  assign res_o.message_done = done_q;
  assign res_o.status       = status_q;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives unpadded base64url messages into the stream decoder, one character
// per request, and checks every decoded byte and end-of-message status
// against a cycle-free decoder model kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CountWidth = 20;
  localparam int unsigned RandItems  = 1450;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned DrainWait  = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       message_done;
    logic [2:0] status;
  } decoded_result_t;

  class decode_scoreboard;
    logic [b64d_pkg::ExpWidth-1:0] want_count;
    logic [1:0]            group_pos;
    logic [5:0]            prev_val;
    logic                  err_seen;
    logic [CountWidth-1:0] emitted;
    decoded_result_t       awaited[$];
    int unsigned           failures;

    function new();
      want_count = '0;
      group_pos  = '0;
      prev_val   = '0;
      err_seen   = 1'b0;
      emitted    = '0;
      failures   = 0;
    endfunction

    // {invalid, value}
    function logic [6:0] decode_char(logic [7:0] ch);
      if (ch >= "A" && ch <= "Z") return {1'b0, 6'(ch - "A")};
      if (ch >= "a" && ch <= "z") return {1'b0, 6'(ch - "a" + 26)};
      if (ch >= "0" && ch <= "9") return {1'b0, 6'(ch - "0" + 52)};
      if (ch == "-") return 7'd62;
      if (ch == "_") return 7'd63;
      return 7'h40;
    endfunction

    function logic [CountWidth-1:0] bump(logic [CountWidth-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function void set_count(logic [b64d_pkg::ExpWidth-1:0] v);
      want_count = v;
    endfunction

    function void note_char(logic [7:0] ch, logic last);
      logic [6:0]      sx;
      logic            bad;
      logic [5:0]      val;
      logic [7:0]      octet;
      logic [2:0]      st;
      decoded_result_t r;
      sx    = decode_char(ch);
      bad   = sx[6];
      val   = sx[5:0];
      octet = '0;
      case (group_pos)
        2'd1: octet = {prev_val, val[5:4]};
        2'd2: octet = {prev_val[3:0], val[5:2]};
        2'd3: octet = {prev_val[1:0], val};
        default: octet = '0;
      endcase
      if (!last) begin
        if (bad) err_seen = 1'b1;
        if (!err_seen && group_pos != 2'd0) begin
          r = '{data_byte: octet, has_byte: 1'b1, message_done: 1'b0,
                status: b64d_pkg::StatusOk};
          awaited.push_back(r);
          emitted = bump(emitted);
        end
        prev_val  = val;
        group_pos = group_pos + 2'd1;
        return;
      end
      // precedence: length, character, tail bits, size
      if (group_pos == 2'd0)
        st = b64d_pkg::StatusBadLen;
      else if (err_seen || bad)
        st = b64d_pkg::StatusBadChar;
      else if ((group_pos == 2'd1 && val[3:0] != 4'd0) ||
               (group_pos == 2'd2 && val[1:0] != 2'd0))
        st = b64d_pkg::StatusBadTail;
      else if (CountWidth'(bump(emitted)) != CountWidth'(want_count))
        st = b64d_pkg::StatusSizeMism;
      else
        st = b64d_pkg::StatusOk;
      r = '{data_byte: (st == b64d_pkg::StatusOk) ? octet : 8'h00,
            has_byte: (st == b64d_pkg::StatusOk), message_done: 1'b1, status: st};
      awaited.push_back(r);
      group_pos = '0;
      prev_val  = '0;
      err_seen  = 1'b0;
      emitted   = '0;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(decoded_result_t got);
      decoded_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        failures++;
        return;
      end
      want = awaited.pop_front();
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("has_byte", 8'(want.has_byte), 8'(got.has_byte));
      compare_field("message_done", 8'(want.message_done), 8'(got.message_done));
      compare_field("status", 8'(want.status), 8'(got.status));
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  b64d_char_if in_if ();
  b64d_cfg_if  cfg_if ();
  b64d_res_if  res_if ();

  base64url_stream_decoder_top #(
    .COUNT_WIDTH (CountWidth)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  decode_scoreboard sb = new();

  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned items_sent;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side: random back-pressure and checking
  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) begin
      sb.check_result('{data_byte: res_if.data_byte, has_byte: res_if.has_byte,
                        message_done: res_if.message_done, status: res_if.status});
    end
    res_if.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] char_of(logic [5:0] val);
    if (val < 26) return 8'("A" + val);
    if (val < 52) return 8'("a" + val - 26);
    if (val < 62) return 8'("0" + val - 52);
    return (val == 6'd62) ? 8'("-") : 8'("_");
  endfunction

  // leaves valid high so that back-to-back requests need no re-arm
  task automatic send_char(logic [7:0] ch, logic last);
    if ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= ch;
    in_if.is_last   <= last;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_char(ch, last);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // register may only change once the decoder has gone quiet
  task automatic drain_then_write(logic [b64d_pkg::ExpWidth-1:0] v);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    cfg_if.valid               <= 1'b1;
    cfg_if.expected_byte_count <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.set_count(v);
  endtask

  task automatic send_random_message(logic [b64d_pkg::ExpWidth-1:0] want);
    int unsigned kind;
    int unsigned len;
    int unsigned target;
    logic [5:0]  val;
    logic [7:0]  ch;
    kind = $urandom_range(99);
    if (kind < 70) begin
      target = (want >= 1 && want <= 30) ? int'(want) : $urandom_range(1, 12);
      len    = 4 * (target / 3) + (((target % 3) == 0) ? 0 : target % 3 + 1);
    end else begin
      len = $urandom_range(1, 16);
    end
    for (int i = 0; i < len; i++) begin
      val = 6'($urandom());
      // well-formed tail: unused low bits cleared most of the time
      if (kind < 70 && i == len - 1 && $urandom_range(9) != 0) begin
        if (len % 4 == 2) val &= 6'h30;
        else if (len % 4 == 3) val &= 6'h3c;
      end
      ch = char_of(val);
      if (kind >= 70 && kind < 85 && $urandom_range(3) == 0) ch = 8'($urandom_range(255));
      send_char(ch, i == len - 1);
    end
  endtask

  initial begin
    logic [b64d_pkg::ExpWidth-1:0] want;
    int unsigned         pick;
    in_if.valid                = 1'b0;
    in_if.char_code            = '0;
    in_if.is_last              = 1'b0;
    cfg_if.valid               = 1'b0;
    cfg_if.expected_byte_count = '0;
    res_if.ready               = 1'b0;
    send_gap_pct               = 27;
    recv_stall_pct             = 61;
    items_sent                 = 0;
    quiet_cycles               = 0;
    rst_ni                     = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: size mismatch at the top count, then the other end cases
    drain_then_write('1);
    send_text("AZaz");
    drain_then_write(20'd3);
    send_text("-_09");
    send_text("A");
    send_text("AB");
    send_text("AAB");
    send_char(8'h00, 1'b0);
    send_text("AA");
    send_char("A", 1'b0);
    send_char(8'hff, 1'b1);
    send_text("AAA");

    items_sent = 0;
    while (items_sent < RandItems) begin
      if (items_sent < RandItems / 3) begin
        send_gap_pct   = 27;
        recv_stall_pct = 61;
      end else if (items_sent < 2 * RandItems / 3) begin
        send_gap_pct   = 61;
        recv_stall_pct = 27;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 70) want = 20'($urandom_range(1, 12));
      else if (pick < 80) want = '0;
      else if (pick < 90) want = '1;
      else want = 20'($urandom());
      drain_then_write(want);
      repeat ($urandom_range(2, 6)) send_random_message(want);
    end

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.outstanding() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time,
               sb.outstanding());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
